### rtl/fisp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fisp_pkg
// Shared types and constants of the flux image stream parser.
// ----------------------------------------------------------------------------
package fisp_pkg;

    localparam int MAX_TRACK_BYTES = 1048576;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0]  TRACK_LIMIT_RESET = 8'd84;
    localparam logic [31:0] SIGNATURE         = 32'h44464532;  // "DFE2"
    localparam logic [7:0]  FLUX_CARRY        = 8'h7f;

    // result kinds
    localparam logic [1:0] KIND_PULSE  = 2'd0;
    localparam logic [1:0] KIND_INDEX  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // error codes
    localparam logic [3:0] ERR_NO_HEADER    = 4'd0;
    localparam logic [3:0] ERR_BAD_SIG      = 4'd1;
    localparam logic [3:0] ERR_SHORT_CHUNK  = 4'd2;
    localparam logic [3:0] ERR_EXCESS_TRK   = 4'd3;
    localparam logic [3:0] ERR_HEAD_ORDER   = 4'd4;
    localparam logic [3:0] ERR_HEAD_RANGE   = 4'd5;
    localparam logic [3:0] ERR_BAD_TRACK    = 4'd6;
    localparam logic [3:0] ERR_HARD_SECTOR  = 4'd7;
    localparam logic [3:0] ERR_TRACK_LARGE  = 4'd8;
    localparam logic [3:0] ERR_SHORT_DATA   = 4'd9;

    // operations handed from front to back
    localparam logic [2:0] OP_PULSE  = 3'd0;
    localparam logic [2:0] OP_INDEX  = 3'd1;
    localparam logic [2:0] OP_CARRY  = 3'd2;
    localparam logic [2:0] OP_CHUNK  = 3'd3;
    localparam logic [2:0] OP_FINISH = 3'd4;
    localparam logic [2:0] OP_ERROR  = 3'd5;

    // val: flux byte, error code or track number depending on op
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] val;
        logic       head;
        logic [1:0] sides;
    } t_op;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage
`default_nettype wire

### rtl/fisp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fisp_front
// Accepts file bytes, checks signature and chunk headers, classifies flux
// bytes into operations for the back end.
// ----------------------------------------------------------------------------
module fisp_front #(
    parameter int MAX_TRACK_BYTES = fisp_pkg::MAX_TRACK_BYTES
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [7:0]             i_cfg_data,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire  [7:0]             i_data_byte,
    input  wire                    i_end_of_file,
    input  fisp_pkg::t_q_status    i_q_status,
    output logic                   o_push,
    output fisp_pkg::t_op          o_push_op
);

    localparam int BLW = $clog2(MAX_TRACK_BYTES + 1);
    localparam logic [31:0] MAX_LEN = 32'(MAX_TRACK_BYTES);

    localparam logic [1:0] PH_SIG  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_HALT = 2'd3;

    logic [1:0]     r_phase, n_phase;
    logic [3:0]     r_pos, n_pos;
    logic [71:0]    r_shift, n_shift;
    logic [8:0]     r_trk, n_trk;          // all ones before the first track
    logic           r_head_vld, n_head_vld;
    logic           r_head, n_head;
    logic           r_two_sided, n_two_sided;
    logic [BLW-1:0] r_left, n_left;
    logic [7:0]     r_limit;

    logic        accept;
    logic [79:0] hdr;
    logic [15:0] h_trk, h_head, h_sec;
    logic [31:0] h_len;
    logic [8:0]  trk_inc;

    assign o_in_ready = (r_phase == PH_HALT) || !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;

    assign hdr    = {r_shift, i_data_byte};
    assign h_trk  = hdr[79:64];
    assign h_head = hdr[63:48];
    assign h_sec  = hdr[47:32];
    assign h_len  = hdr[31:0];
    assign trk_inc = r_trk + 9'd1;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_shift     = r_shift;
        n_trk       = r_trk;
        n_head_vld  = r_head_vld;
        n_head      = r_head;
        n_two_sided = r_two_sided;
        n_left      = r_left;
        o_push      = 1'b0;
        o_push_op   = '0;

        if (accept) begin
            unique case (r_phase)
                PH_SIG: begin
                    if (i_end_of_file) begin
                        o_push        = 1'b1;
                        o_push_op.op  = fisp_pkg::OP_ERROR;
                        o_push_op.val = {4'd0, fisp_pkg::ERR_NO_HEADER};
                        n_phase       = PH_HALT;
                    end else begin
                        n_shift = {r_shift[63:0], i_data_byte};
                        n_pos   = r_pos + 4'd1;
                        if (r_pos == 4'd3) begin
                            n_pos = 4'd0;
                            if ({r_shift[23:0], i_data_byte} != fisp_pkg::SIGNATURE) begin
                                o_push        = 1'b1;
                                o_push_op.op  = fisp_pkg::OP_ERROR;
                                o_push_op.val = {4'd0, fisp_pkg::ERR_BAD_SIG};
                                n_phase       = PH_HALT;
                            end else begin
                                n_phase = PH_HDR;
                            end
                        end
                    end
                end
                PH_HDR: begin
                    if (i_end_of_file) begin
                        o_push  = 1'b1;
                        n_phase = PH_HALT;
                        if (r_pos != 4'd0) begin
                            o_push_op.op  = fisp_pkg::OP_ERROR;
                            o_push_op.val = {4'd0, fisp_pkg::ERR_SHORT_CHUNK};
                        end else begin
                            o_push_op.op    = fisp_pkg::OP_FINISH;
                            o_push_op.val   = trk_inc[7:0];
                            o_push_op.sides = r_two_sided ? 2'd2 : 2'd1;
                        end
                    end else begin
                        n_shift = {r_shift[63:0], i_data_byte};
                        n_pos   = r_pos + 4'd1;
                        if (r_pos == 4'd9) begin
                            n_pos         = 4'd0;
                            o_push        = 1'b1;
                            o_push_op.op  = fisp_pkg::OP_ERROR;
                            n_phase       = PH_HALT;
                            // checks in priority order; head first
                            if (h_head == 16'd0) begin
                                n_trk      = trk_inc;
                                n_head_vld = 1'b1;
                                n_head     = 1'b0;
                            end else if (h_head == 16'd1) begin
                                n_head     = 1'b1;
                                n_two_sided = 1'b1;
                            end
                            if (h_head == 16'd0 && trk_inc >= {1'b0, r_limit}) begin
                                o_push_op.val = {4'd0, fisp_pkg::ERR_EXCESS_TRK};
                            end else if (h_head == 16'd1 && !(r_head_vld && !r_head)) begin
                                o_push_op.val = {4'd0, fisp_pkg::ERR_HEAD_ORDER};
                            end else if (h_head > 16'd1) begin
                                o_push_op.val = {4'd0, fisp_pkg::ERR_HEAD_RANGE};
                            end else if (h_trk != {7'd0, n_trk}) begin
                                o_push_op.val = {4'd0, fisp_pkg::ERR_BAD_TRACK};
                            end else if (h_sec != 16'd1) begin
                                o_push_op.val = {4'd0, fisp_pkg::ERR_HARD_SECTOR};
                            end else if (h_len > MAX_LEN) begin
                                o_push_op.val = {4'd0, fisp_pkg::ERR_TRACK_LARGE};
                            end else begin
                                o_push_op.op   = fisp_pkg::OP_CHUNK;
                                o_push_op.val  = n_trk[7:0];
                                o_push_op.head = n_head;
                                n_left         = h_len[BLW-1:0];
                                n_phase        = (h_len == 32'd0) ? PH_HDR : PH_DATA;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    o_push = 1'b1;
                    if (i_end_of_file) begin
                        o_push_op.op  = fisp_pkg::OP_ERROR;
                        o_push_op.val = {4'd0, fisp_pkg::ERR_SHORT_DATA};
                        n_phase       = PH_HALT;
                    end else begin
                        o_push_op.val = i_data_byte;
                        if (i_data_byte[7]) begin
                            o_push_op.op = fisp_pkg::OP_INDEX;
                        end else if (i_data_byte == fisp_pkg::FLUX_CARRY) begin
                            o_push_op.op = fisp_pkg::OP_CARRY;
                        end else begin
                            o_push_op.op = fisp_pkg::OP_PULSE;
                        end
                        n_left = r_left - BLW'(1);
                        if (r_left == BLW'(1)) begin
                            n_phase = PH_HDR;
                        end
                    end
                end
                default: begin
                    // halted: items are taken and dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_pos       <= 4'd0;
            r_shift     <= '0;
            r_trk       <= '1;
            r_head_vld  <= 1'b0;
            r_head      <= 1'b0;
            r_two_sided <= 1'b0;
            r_left      <= '0;
            r_limit     <= fisp_pkg::TRACK_LIMIT_RESET;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_shift     <= n_shift;
            r_trk       <= n_trk;
            r_head_vld  <= n_head_vld;
            r_head      <= n_head;
            r_two_sided <= n_two_sided;
            r_left      <= n_left;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/fisp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fisp_queue
// Small operation queue between front and back end.
// ----------------------------------------------------------------------------
module fisp_queue #(
    parameter int DEPTH = fisp_pkg::QUEUE_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  fisp_pkg::t_op        i_push_op,
    input  wire                  i_pop,
    output fisp_pkg::t_op        o_head_op,
    output fisp_pkg::t_q_status  o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fisp_pkg::t_op r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_head_op       = r_mem[r_rd];
    assign o_status.empty  = (r_cnt == CW'(0));
    assign o_status.full   = (r_cnt == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/fisp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fisp_back
// Executes queued operations: flux accumulation, revolution counting and
// the registered result stage.
// ----------------------------------------------------------------------------
module fisp_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  fisp_pkg::t_op        i_head_op,
    input  fisp_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [1:0]           o_kind,
    output logic [19:0]          o_delta_ns,
    output logic [19:0]          o_revolution,
    output logic [20:0]          o_pulse_count,
    output logic                 o_head_number,
    output logic [7:0]           o_track_number,
    output logic [1:0]           o_sides_found,
    output logic [3:0]           o_error_code
);

    logic [15:0] r_acc;
    logic [19:0] r_rev;
    logic [20:0] r_pulses;
    logic        r_head;
    logic [7:0]  r_trk;
    logic        r_out_valid;

    logic        has_result, out_free;
    logic [15:0] sum;
    logic [19:0] delta;

    assign has_result = (i_head_op.op != fisp_pkg::OP_CARRY) &&
                        (i_head_op.op != fisp_pkg::OP_CHUNK);
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_pop      = !i_q_status.empty && (!has_result || out_free);

    assign sum   = r_acc + {8'd0, i_head_op.val};
    // times 12 as 8x + 4x
    assign delta = {1'b0, sum, 3'b000} + {2'b00, sum, 2'b00};

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_rev       <= '0;
            r_pulses    <= '0;
        end else begin
            if (o_pop && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                case (i_head_op.op)
                    fisp_pkg::OP_CHUNK: begin
                        r_acc    <= '0;
                        r_rev    <= '0;
                        r_pulses <= '0;
                    end
                    fisp_pkg::OP_CARRY: begin
                        r_acc <= sum;
                    end
                    fisp_pkg::OP_INDEX: begin
                        r_acc    <= r_acc + {9'd0, i_head_op.val[6:0]};
                        r_rev    <= r_rev + 20'd1;
                        r_pulses <= '0;
                    end
                    fisp_pkg::OP_PULSE: begin
                        r_acc    <= '0;
                        r_pulses <= r_pulses + 21'd1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // chunk context and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head_op.op == fisp_pkg::OP_CHUNK) begin
            r_head <= i_head_op.head;
            r_trk  <= i_head_op.val;
        end
        if (o_pop && has_result) begin
            o_delta_ns     <= '0;
            o_revolution   <= '0;
            o_pulse_count  <= '0;
            o_head_number  <= 1'b0;
            o_track_number <= '0;
            o_sides_found  <= '0;
            o_error_code   <= '0;
            case (i_head_op.op)
                fisp_pkg::OP_PULSE: begin
                    o_kind         <= fisp_pkg::KIND_PULSE;
                    o_delta_ns     <= delta;
                    o_head_number  <= r_head;
                    o_track_number <= r_trk;
                end
                fisp_pkg::OP_INDEX: begin
                    o_kind         <= fisp_pkg::KIND_INDEX;
                    o_revolution   <= r_rev;
                    o_pulse_count  <= r_pulses;
                    o_head_number  <= r_head;
                    o_track_number <= r_trk;
                end
                fisp_pkg::OP_FINISH: begin
                    o_kind         <= fisp_pkg::KIND_FINISH;
                    o_track_number <= i_head_op.val;
                    o_sides_found  <= i_head_op.sides;
                end
                default: begin
                    o_kind       <= fisp_pkg::KIND_ERROR;
                    o_error_code <= i_head_op.val[3:0];
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/flux_image_stream_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flux_image_stream_parser_top
// Flux image file parser: signature, chunk headers and flux decoding.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one file byte per item, or
// an end-of-file mark. Output channel (o_out_valid / i_out_ready) carries
// pulse, index, finished and error results; at most one per input item.
// The front end takes one item per cycle while the queue is not full, checks
// the signature and 10-byte chunk headers and sorts flux bytes into
// operations for a small queue. The back end drains one operation per cycle
// unless the operation gives a result and the result register is held; it
// keeps the flux accumulator and revolution counters and fills the result
// register. A result's operation is queued before the result is registered.
// Throughput: one item per cycle while the receiver takes results, limited by
// the single result register and the one-push/one-pop queue.
// When the receiver stalls, the queue fills and o_in_ready drops once it is
// full; items that give no result still need a free queue slot. After an error
// or finished result, further items are accepted and dropped until reset.
// Reset restores the track limit to 84 and clears all parsing state. i_cfg_we
// writes the track limit; the user must write it only while idle, the block does not check.
// ----------------------------------------------------------------------------
module flux_image_stream_parser_top #(
    parameter int MAX_TRACK_BYTES = fisp_pkg::MAX_TRACK_BYTES,
    parameter int QUEUE_DEPTH     = fisp_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_end_of_file,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_kind,
    output logic [19:0] o_delta_ns,
    output logic [19:0] o_revolution,
    output logic [20:0] o_pulse_count,
    output logic        o_head_number,
    output logic [7:0]  o_track_number,
    output logic [1:0]  o_sides_found,
    output logic [3:0]  o_error_code
);

    logic                 push, pop;
    fisp_pkg::t_op        push_op, head_op;
    fisp_pkg::t_q_status  q_status;

    fisp_front #(
        .MAX_TRACK_BYTES (MAX_TRACK_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_push_op     (push_op)
    );

    fisp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (pop),
        .o_head_op (head_op),
        .o_status  (q_status)
    );

    fisp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_op      (head_op),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_delta_ns     (o_delta_ns),
        .o_revolution   (o_revolution),
        .o_pulse_count  (o_pulse_count),
        .o_head_number  (o_head_number),
        .o_track_number (o_track_number),
        .o_sides_found  (o_sides_found),
        .o_error_code   (o_error_code)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_status.full))
        else $error("push into full queue");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_status.empty))
        else $error("pop from empty queue");

    // a terminal result is the last one
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready &&
         (o_kind == fisp_pkg::KIND_ERROR || o_kind == fisp_pkg::KIND_FINISH))
        |=> !o_out_valid && q_status.empty)
        else $error("result after terminal item");

endmodule
`default_nettype wire
